[rtl/assert_macros.svh]
// Assertion macros, included by the top-level core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// property must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

[rtl/tdpt_pkg.sv]
// Shared widths, types and status struct for the trial division prime tester.
package tdpt_pkg;

    localparam int NUM_W    = 31;                              // tested number width
    localparam int CFG_W    = 16;                              // first divisor register
    localparam int ROOT_W   = (NUM_W + 1) / 2;                 // integer square root width
    localparam int DIV_W    = ((ROOT_W > CFG_W) ? ROOT_W : CFG_W) + 1;
    localparam int SQ_X_W   = 2 * ROOT_W;                      // radicand, padded to even
    localparam int SQ_REM_W = ROOT_W + 2;
    localparam int SQ_CNT_W = $clog2(ROOT_W + 1);
    localparam int RM_CNT_W = $clog2(NUM_W + 1);

    typedef logic [NUM_W-1:0]    t_num;
    typedef logic [CFG_W-1:0]    t_cfg;
    typedef logic [ROOT_W-1:0]   t_root;
    typedef logic [DIV_W-1:0]    t_div;
    typedef logic [SQ_X_W-1:0]   t_sq_x;
    typedef logic [SQ_REM_W-1:0] t_sq_rem;

    // status of a serial arithmetic unit
    typedef struct packed {
        logic busy;   // iterating
        logic done;   // result valid this cycle
    } t_unit_stat;

endpackage

[rtl/tdpt_isqrt.sv]
// Bit-serial integer square root: one root bit per cycle.
module tdpt_isqrt (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  tdpt_pkg::t_num        i_value,
    output tdpt_pkg::t_unit_stat  o_stat,
    output tdpt_pkg::t_root       o_root
);

    logic                                r_busy;
    logic [tdpt_pkg::SQ_CNT_W-1:0]       r_cnt;
    tdpt_pkg::t_sq_x                     r_x;
    tdpt_pkg::t_sq_rem                   r_rem;
    tdpt_pkg::t_root                     r_root;

    logic [tdpt_pkg::SQ_REM_W+1:0]       w_rem_sh;
    logic [tdpt_pkg::SQ_REM_W+1:0]       w_trial;
    logic [tdpt_pkg::SQ_REM_W+1:0]       w_diff;
    logic                                w_ge;

    // bring down the next two radicand bits, try root*4+1
    assign w_rem_sh = {r_rem, r_x[tdpt_pkg::SQ_X_W-1 -: 2]};
    assign w_trial  = {2'b00, r_root, 2'b01};
    assign w_diff   = w_rem_sh - w_trial;
    assign w_ge     = (w_rem_sh >= w_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= tdpt_pkg::SQ_CNT_W'(tdpt_pkg::ROOT_W);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= tdpt_pkg::t_sq_x'(i_value);
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy && r_cnt != '0) begin
            r_x    <= {r_x[tdpt_pkg::SQ_X_W-3:0], 2'b00};
            r_rem  <= w_ge ? w_diff[tdpt_pkg::SQ_REM_W-1:0]
                           : w_rem_sh[tdpt_pkg::SQ_REM_W-1:0];
            r_root <= {r_root[tdpt_pkg::ROOT_W-2:0], w_ge};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_busy && (r_cnt == '0);
    assign o_root      = r_root;

endmodule

[rtl/tdpt_rem.sv]
// Bit-serial restoring remainder: one dividend bit per cycle.
module tdpt_rem (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  tdpt_pkg::t_num        i_dividend,
    input  tdpt_pkg::t_div        i_divisor,
    output tdpt_pkg::t_unit_stat  o_stat,
    output logic                  o_zero
);

    logic                                r_busy;
    logic [tdpt_pkg::RM_CNT_W-1:0]       r_cnt;
    tdpt_pkg::t_num                      r_n;
    tdpt_pkg::t_div                      r_d;
    tdpt_pkg::t_div                      r_r;

    logic [tdpt_pkg::DIV_W:0]            w_sh;
    logic [tdpt_pkg::DIV_W:0]            w_diff;
    logic                                w_ge;

    assign w_sh   = {r_r, r_n[tdpt_pkg::NUM_W-1]};
    assign w_diff = w_sh - {1'b0, r_d};
    assign w_ge   = (w_sh >= {1'b0, r_d});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= tdpt_pkg::RM_CNT_W'(tdpt_pkg::NUM_W);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n <= i_dividend;
            r_d <= i_divisor;
            r_r <= '0;
        end else if (r_busy && r_cnt != '0) begin
            r_n <= {r_n[tdpt_pkg::NUM_W-2:0], 1'b0};
            r_r <= w_ge ? w_diff[tdpt_pkg::DIV_W-1:0] : w_sh[tdpt_pkg::DIV_W-1:0];
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_busy && (r_cnt == '0);
    assign o_zero      = (r_r == '0);

endmodule

[rtl/trial_division_prime_test_core.sv]
// Trial division prime tester: top level with control sequencer.
//
// Usage:
//  - Command channel: drive i_number and pulse i_start while o_busy is low;
//    the transfer happens at that clock edge. For numbers above one, o_busy
//    stays high until the result has been produced.
//  - Result channel: o_valid is high for exactly one cycle with
//    o_tested_number (echo) and o_prime_flag. The receiver cannot stall;
//    the result must be captured in that cycle.
//  - Config channel: i_cfg_valid/o_cfg_ready write first_divisor; ready is
//    high while idle. Values 0 and 1 act as 2.
// Operation (NUM_W = 31):
//  - 0 and 1: result in the cycle after the start transfer.
//  - otherwise: the bit-serial root unit first finds the square root,
//    then each trial divisor is tried in turn in the bit-serial
//    remainder unit, and the result is strobed at the end. The worst
//    case is a prime near 2^31, tried against every divisor up to its root.
//  - A new command can be taken in the cycle the result is strobed.
// Reset: synchronous active low; returns to idle, first_divisor = 2.
module trial_division_prime_test_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // command channel
    input  logic                  i_start,
    output logic                  o_busy,
    input  tdpt_pkg::t_num        i_number,
    // result channel
    output logic                  o_valid,
    output tdpt_pkg::t_num        o_tested_number,
    output logic                  o_prime_flag,
    // config channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  tdpt_pkg::t_cfg        i_cfg_first_divisor
);

`include "assert_macros.svh"

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SQRT = 2'd1;   // root unit running
    localparam logic [1:0] ST_DIV  = 2'd2;   // remainder unit running

    logic [1:0]            r_state;
    tdpt_pkg::t_cfg        r_first;
    tdpt_pkg::t_div        r_div;          // current trial divisor
    tdpt_pkg::t_div        r_limit;        // floor(sqrt(number)), widened
    tdpt_pkg::t_num        r_number;
    logic                  r_valid;
    logic                  r_prime;

    logic                  w_accept;
    logic                  w_sqrt_start;
    logic                  w_rem_start;
    tdpt_pkg::t_div        w_rem_div;
    tdpt_pkg::t_div        w_div_init;
    tdpt_pkg::t_div        w_root_ext;
    tdpt_pkg::t_unit_stat  w_sq_stat;
    tdpt_pkg::t_unit_stat  w_rm_stat;
    tdpt_pkg::t_root       w_root;
    logic                  w_rem_zero;

    assign w_accept     = i_start && (r_state == ST_IDLE);
    assign w_sqrt_start = w_accept && (i_number > tdpt_pkg::NUM_W'(1));
    assign w_root_ext   = tdpt_pkg::t_div'(w_root);
    // divisors below two are forced to two
    assign w_div_init   = (r_first < tdpt_pkg::CFG_W'(2)) ? tdpt_pkg::DIV_W'(2)
                                                          : tdpt_pkg::t_div'(r_first);

    // launch the remainder unit after the root, or on the next divisor
    always_comb begin
        w_rem_start = 1'b0;
        w_rem_div   = r_div;
        if (r_state == ST_SQRT && w_sq_stat.done && r_div <= w_root_ext) begin
            w_rem_start = 1'b1;
        end else if (r_state == ST_DIV && w_rm_stat.done && !w_rem_zero
                     && r_div < r_limit) begin
            w_rem_start = 1'b1;
            w_rem_div   = r_div + tdpt_pkg::DIV_W'(1);
        end
    end

    tdpt_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sqrt_start),
        .i_value (i_number),
        .o_stat  (w_sq_stat),
        .o_root  (w_root)
    );

    tdpt_rem u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_rem_start),
        .i_dividend (r_number),
        .i_divisor  (w_rem_div),
        .o_stat     (w_rm_stat),
        .o_zero     (w_rem_zero)
    );

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first <= tdpt_pkg::CFG_W'(2);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_first <= i_cfg_first_divisor;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        if (w_sqrt_start) begin
                            r_state <= ST_SQRT;
                        end else begin
                            r_valid <= 1'b1;       // 0 and 1 are not prime
                        end
                    end
                end
                ST_SQRT: begin
                    if (w_sq_stat.done) begin
                        if (w_rem_start) begin
                            r_state <= ST_DIV;
                        end else begin
                            r_state <= ST_IDLE;    // first divisor above root
                            r_valid <= 1'b1;
                        end
                    end
                end
                ST_DIV: begin
                    if (w_rm_stat.done && !w_rem_start) begin
                        r_state <= ST_IDLE;
                        r_valid <= 1'b1;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_number <= i_number;
            r_div    <= w_div_init;
            r_prime  <= 1'b0;
        end
        if (r_state == ST_SQRT && w_sq_stat.done) begin
            r_limit <= w_root_ext;
            if (!w_rem_start) begin
                r_prime <= 1'b1;
            end
        end
        if (r_state == ST_DIV && w_rm_stat.done) begin
            r_div   <= w_rem_div;
            r_prime <= !w_rem_zero;
        end
    end

    assign o_busy          = (r_state != ST_IDLE);
    assign o_cfg_ready     = (r_state == ST_IDLE);
    assign o_valid         = r_valid;
    assign o_tested_number = r_number;
    assign o_prime_flag    = r_prime;

    // a result only follows work in progress
    `ASSERT_PROP(a_valid_after_busy, i_clk, i_rst_n, o_valid |-> $past(o_busy) || $past(i_start))
    // the two serial units never run together
    `ASSERT_NEVER(a_units_exclusive, i_clk, i_rst_n, w_sq_stat.busy && w_rm_stat.busy)
    // numbers below two never come out prime
    `ASSERT_PROP(a_small_not_prime, i_clk, i_rst_n, (o_valid && o_prime_flag) |-> (o_tested_number > tdpt_pkg::NUM_W'(1)))
    // trial divisor stays within the root while dividing
    `ASSERT_PROP(a_div_in_range, i_clk, i_rst_n, (r_state == ST_DIV) |-> (r_div <= r_limit))

endmodule

[sim/tb_trial_division_prime_test_core.sv]
// Self-checking testbench for the trial division prime tester core.
`timescale 1ns / 100ps

module tb_trial_division_prime_test_core;

    // Random numbers are redrawn until the core tries fewer divisors than
    // this, which keeps the run time of every item bounded.
    localparam int unsigned TRIAL_CAP   = 128;
    localparam int unsigned CYCLE_LIMIT = 2_000_000;
    // settle time after the last result, before a register write or the end
    localparam int unsigned SETTLE_CYC  = 4;
    localparam int unsigned END_CYC     = 40;
    localparam int unsigned MAX_GAP     = 40;

    // one expected result: echo of the number and the prime flag
    typedef struct packed {
        tdpt_pkg::t_num number;
        logic           prime;
    } t_prime_verdict;

    logic            i_clk;
    logic            i_rst_n;
    logic            i_start;
    logic            o_busy;
    tdpt_pkg::t_num  i_number;
    logic            o_valid;
    tdpt_pkg::t_num  o_tested_number;
    logic            o_prime_flag;
    logic            i_cfg_valid;
    logic            o_cfg_ready;
    tdpt_pkg::t_cfg  i_cfg_first_divisor;

    t_prime_verdict  pending_verdicts[$];
    tdpt_pkg::t_cfg  first_divisor_setting;  // shadow of the register
    int unsigned     send_idle_pct;          // chance per cycle that the sender holds off
    int unsigned     fail_count;
    int unsigned     cycle_count;

    trial_division_prime_test_core uut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_start             (i_start),
        .o_busy              (o_busy),
        .i_number            (i_number),
        .o_valid             (o_valid),
        .o_tested_number     (o_tested_number),
        .o_prime_flag        (o_prime_flag),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_first_divisor (i_cfg_first_divisor)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Floor of the square root by bisection; the bound holds for x < 2^32.
    function automatic longint unsigned floor_sqrt(input longint unsigned x);
        longint unsigned lo, hi, mid;
        lo = 0;
        hi = 65536;
        while (hi - lo > 1) begin
            mid = (lo + hi) / 2;
            if (mid * mid <= x) lo = mid;
            else                hi = mid;
        end
        return lo;
    endfunction

    // Prime flag as the core computes it. Also reports how many divisors
    // were tried; the search gives up at max_trials (flag then meaningless).
    function automatic logic predict_prime(input tdpt_pkg::t_num n,
                                           input tdpt_pkg::t_cfg first,
                                           input int unsigned max_trials,
                                           output int unsigned trials);
        longint unsigned root, d;
        trials = 0;
        if (n <= 1) return 1'b0;
        root = floor_sqrt(n);
        // first divisor codes 0 and 1 behave as 2
        d = (first < 2) ? 2 : first;
        while (d <= root) begin
            trials++;
            if (n % d == 0) return 1'b0;
            if (trials >= max_trials) return 1'b1;
            d++;
        end
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Result checker: every strobe is matched against the oldest verdict.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : check_results
        t_prime_verdict want;
        if (i_rst_n && o_valid) begin
            if (pending_verdicts.size() == 0) begin
                $display("%0t: result with nothing pending: tested_number %0d prime_flag %0b",
                         $time, o_tested_number, o_prime_flag);
                fail_count++;
            end else begin
                want = pending_verdicts.pop_front();
                if (o_tested_number !== want.number) begin
                    $display("%0t: tested_number expected %0d actual %0d",
                             $time, want.number, o_tested_number);
                    fail_count++;
                end
                if (o_prime_flag !== want.prime) begin
                    $display("%0t: prime_flag for %0d expected %0b actual %0b",
                             $time, want.number, want.prime, o_prime_flag);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: a hung core or a lost handshake ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results still pending", $time,
                     pending_verdicts.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // One command transfer. The sender first idles a random number of
    // cycles; with no idle, start stays high straight through from the
    // previous transfer so back-to-back commands wait on busy alone.
    task automatic send_number(input tdpt_pkg::t_num n);
        int unsigned    gap;
        int unsigned    trials;
        logic           verdict;
        t_prime_verdict entry;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
        if (gap != 0) begin
            @(negedge i_clk);
            i_start  <= 1'b0;
            i_number <= tdpt_pkg::t_num'($urandom);   // junk while idle
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_start  <= 1'b1;
        i_number <= n;
        // transfer happens at the first edge that sees busy low
        do @(posedge i_clk); while (o_busy);
        verdict = predict_prime(n, first_divisor_setting, '1, trials);
        entry   = '{number: n, prime: verdict};
        pending_verdicts.insert(pending_verdicts.size(), entry);
    endtask

    // Stop sending and let every outstanding result come back.
    task automatic drain_results();
        @(negedge i_clk);
        i_start <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    // Register write, only with the core idle.
    task automatic write_first_divisor(input tdpt_pkg::t_cfg value);
        drain_results();
        @(negedge i_clk);
        i_cfg_valid         <= 1'b1;
        i_cfg_first_divisor <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        first_divisor_setting = value;
        @(negedge i_clk);
        i_cfg_valid         <= 1'b0;
        i_cfg_first_divisor <= tdpt_pkg::t_cfg'($urandom);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset value of the register (2): the trivial numbers, small primes
    // and squares, and the largest even number.
    task automatic test_reset_divisor();
        send_number(tdpt_pkg::t_num'(0));
        send_number(tdpt_pkg::t_num'(1));
        send_number(tdpt_pkg::t_num'(2));
        send_number(tdpt_pkg::t_num'(3));
        send_number(tdpt_pkg::t_num'(4));
        send_number(tdpt_pkg::t_num'(25));
        send_number(tdpt_pkg::t_num'(49));
        send_number(tdpt_pkg::t_num'(97));
        send_number(tdpt_pkg::t_num'(2147483646));
    endtask

    // Divisor codes 0 and 1 must behave as 2.
    task automatic test_low_divisor_codes();
        write_first_divisor(tdpt_pkg::t_cfg'(0));
        send_number(tdpt_pkg::t_num'(4));
        send_number(tdpt_pkg::t_num'(9));
        send_number(tdpt_pkg::t_num'(7));
        write_first_divisor(tdpt_pkg::t_cfg'(1));
        send_number(tdpt_pkg::t_num'(3));
        send_number(tdpt_pkg::t_num'(8));
        send_number(tdpt_pkg::t_num'(15));
    endtask

    // First divisor above, at and just below the square root. 2147117569
    // is 46337 squared and 46340 is the root of the largest number, so the
    // exact root decides these verdicts.
    task automatic test_root_boundaries();
        write_first_divisor(tdpt_pkg::t_cfg'(65535));
        send_number(tdpt_pkg::t_num'(2147483647));
        send_number(tdpt_pkg::t_num'(2147483646));
        send_number(tdpt_pkg::t_num'(2));
        write_first_divisor(tdpt_pkg::t_cfg'(46337));
        send_number(tdpt_pkg::t_num'(2147117569));
        send_number(tdpt_pkg::t_num'(2147483647));
        write_first_divisor(tdpt_pkg::t_cfg'(46338));
        send_number(tdpt_pkg::t_num'(2147117569));
    endtask

    // Random numbers of mixed shape under one divisor setting.
    task automatic test_random_traffic(input int unsigned idle_pct,
                                       input tdpt_pkg::t_cfg divisor,
                                       input int unsigned count);
        tdpt_pkg::t_num n;
        int unsigned    root_pick;
        int unsigned    trials;
        logic           unused_flag;
        write_first_divisor(divisor);
        send_idle_pct = idle_pct;
        repeat (count) begin
            do begin
                case ($urandom_range(0, 9)) inside
                    [0:3]:   n = tdpt_pkg::t_num'($urandom)
                                 & ((tdpt_pkg::t_num'(1) << $urandom_range(1, 12))
                                    - tdpt_pkg::t_num'(1));
                    [4:7]:   n = tdpt_pkg::t_num'($urandom);
                    8:       n = tdpt_pkg::t_num'($urandom_range(2, 2000)
                                                  * $urandom_range(2, 2000));
                    default: begin
                        // perfect squares stress the root limit
                        root_pick = $urandom_range(2, 46340);
                        n = tdpt_pkg::t_num'(root_pick * root_pick);
                    end
                endcase
                unused_flag = predict_prime(n, first_divisor_setting, TRIAL_CAP, trials);
            end while (trials >= TRIAL_CAP);
            send_number(n);
        end
    endtask

    initial begin
        i_rst_n               = 1'b0;
        i_start               = 1'b0;
        i_number              = '0;
        i_cfg_valid           = 1'b0;
        i_cfg_first_divisor   = '0;
        first_divisor_setting = tdpt_pkg::t_cfg'(2);
        send_idle_pct         = 22;
        fail_count            = 0;
        cycle_count           = 0;

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_divisor();
        test_low_divisor_codes();
        test_root_boundaries();
        test_random_traffic(22, tdpt_pkg::t_cfg'(2), 27);
        test_random_traffic(79, tdpt_pkg::t_cfg'($urandom_range(0, 64)), 27);
        test_random_traffic(0, tdpt_pkg::t_cfg'($urandom_range(30000, 65535)), 26);

        drain_results();
        repeat (END_CYC) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
